@@ rtl/core/tfbgra_pkg.sv @@
// ----------------------------------------------------------------------------
// tfbgra_pkg
// Shared types, format codes and channel widening tables for the texel
// format to BGRA8888 converter.
// ----------------------------------------------------------------------------
package tfbgra_pkg;

  // source format codes, as written to the source_format register
  typedef enum logic [2:0] {
    FMT_PAL8 = 3'd0,
    FMT_8888 = 3'd1,
    FMT_888  = 3'd2,
    FMT_LUM8 = 3'd3,
    FMT_565  = 3'd4,
    FMT_4444 = 3'd5,
    FMT_1555 = 3'd6,
    FMT_555  = 3'd7
  } fmt_t;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SOURCE_FORMAT     = 2'd0,
    CFG_SOURCE_ALPHA_FLAG = 2'd1
  } cfg_reg_t;

  // input word kinds
  localparam logic KIND_CONVERT   = 1'b0;
  localparam logic KIND_PAL_WRITE = 1'b1;

  localparam int ENTRY_INDEX_W = 8;
  localparam int COLOR_W       = 32;

  localparam logic [7:0] BYTE_OPAQUE = 8'hFF;

  typedef struct packed {
    logic                     kind;
    logic [31:0]              texel_bytes;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0]       entry_color;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic       alpha_present;
  } out_word_t;

  // v*255/31, truncated
  localparam logic [7:0] WIDEN5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // v*255/63, truncated
  localparam logic [7:0] WIDEN6_LUT [64] = '{
    8'd0,   8'd4,   8'd8,   8'd12,  8'd16,  8'd20,  8'd24,  8'd28,
    8'd32,  8'd36,  8'd40,  8'd44,  8'd48,  8'd52,  8'd56,  8'd60,
    8'd64,  8'd68,  8'd72,  8'd76,  8'd80,  8'd85,  8'd89,  8'd93,
    8'd97,  8'd101, 8'd105, 8'd109, 8'd113, 8'd117, 8'd121, 8'd125,
    8'd129, 8'd133, 8'd137, 8'd141, 8'd145, 8'd149, 8'd153, 8'd157,
    8'd161, 8'd165, 8'd170, 8'd174, 8'd178, 8'd182, 8'd186, 8'd190,
    8'd194, 8'd198, 8'd202, 8'd206, 8'd210, 8'd214, 8'd218, 8'd222,
    8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd246, 8'd250, 8'd255
  };

endpackage

@@ rtl/core/tfbgra_palette.sv @@
// ----------------------------------------------------------------------------
// tfbgra_palette
// Palette storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tfbgra_palette
  import tfbgra_pkg::*;
#(
  parameter int ENTRIES = 256,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [COLOR_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [COLOR_W-1:0] rd_data
);

  logic [COLOR_W-1:0] mem [ENTRIES];
  logic [COLOR_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/texel_format_to_bgra8888.sv @@
// Throughput: one word per cycle while out_ready is high; the palette RAM
// port and the widening tables each serve one texel per cycle in a
// three-stage pipeline. Palette writes produce no output word.
// Reset (rst_n low at a clock edge) clears all stage valids, sets the source
// format to 8888 and the alpha flag to 0; palette contents stay undefined.
// ----------------------------------------------------------------------------
// texel_format_to_bgra8888
// Converts one source texel per word to four BGRA bytes plus an alpha flag.
// ----------------------------------------------------------------------------
module texel_format_to_bgra8888
  import tfbgra_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam logic [ENTRY_INDEX_W:0] PAL_LIMIT = (ENTRY_INDEX_W+1)'(PALETTE_ENTRIES);

  // configuration registers
  fmt_t fmt_r;
  logic alpha_flag_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= FMT_8888;
      alpha_flag_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SOURCE_FORMAT:     fmt_r <= fmt_t'(cfg_data[2:0]);
        CFG_SOURCE_ALPHA_FLAG: alpha_flag_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage loads when empty or when it moves on
  logic v1_r, v2_r, v3_r;
  logic s1_take, s2_take, s3_take;

  assign s3_take  = !v3_r || out_ready;
  assign s2_take  = !v2_r || s3_take;
  assign s1_take  = !v1_r || s2_take;
  assign in_ready = s1_take;

  logic in_acc;
  logic is_conv;
  logic wr_hit, rd_hit;

  assign in_acc  = in_valid && in_ready;
  assign is_conv = (in_data.kind == KIND_CONVERT);
  assign wr_hit  = ({1'b0, in_data.entry_index} < PAL_LIMIT);
  assign rd_hit  = ({1'b0, in_data.texel_bytes[7:0]} < PAL_LIMIT);

  // palette access at input acceptance
  logic [COLOR_W-1:0] pal_rd_data;

  tfbgra_palette #(
    .ENTRIES (PALETTE_ENTRIES),
    .AW      (PAL_AW)
  ) u_palette (
    .clk     (clk),
    .wr_en   (in_acc && !is_conv && wr_hit),
    .wr_addr (in_data.entry_index[PAL_AW-1:0]),
    .wr_data (in_data.entry_color),
    .rd_en   (in_acc && is_conv && rd_hit),
    .rd_addr (in_data.texel_bytes[PAL_AW-1:0]),
    .rd_data (pal_rd_data)
  );

  // valid bits travel with the words
  logic v1_nxt, v2_nxt, v3_nxt;

  always_comb begin
    v1_nxt = s1_take ? (in_valid && is_conv) : v1_r;
    v2_nxt = s2_take ? v1_r : v2_r;
    v3_nxt = s3_take ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // stage 1: capture texel, format and lookup range
  logic [31:0] s1_tex_r;
  fmt_t        s1_fmt_r;
  logic        s1_alpha_r;
  logic        s1_hit_r;
  logic        s1_alpha_nxt;

  assign s1_alpha_nxt = alpha_flag_r || (fmt_r inside {FMT_8888, FMT_1555, FMT_4444});

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_tex_r   <= in_data.texel_bytes;
      s1_fmt_r   <= fmt_r;
      s1_alpha_r <= s1_alpha_nxt;
      s1_hit_r   <= rd_hit;
    end
  end

  // stage 2: widen 5 and 6 bit channels, mask out-of-range palette reads
  logic [31:0]        s2_tex_r;
  fmt_t               s2_fmt_r;
  logic               s2_alpha_r;
  logic [COLOR_W-1:0] s2_pal_r;
  logic [7:0]         s2_b5_r, s2_g6_r, s2_g5_r, s2_r565_r, s2_r555_r;
  logic [COLOR_W-1:0] s2_pal_nxt;

  assign s2_pal_nxt = s1_hit_r ? pal_rd_data : '0;

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_tex_r   <= s1_tex_r;
      s2_fmt_r   <= s1_fmt_r;
      s2_alpha_r <= s1_alpha_r;
      s2_pal_r   <= s2_pal_nxt;
      s2_b5_r    <= WIDEN5_LUT[s1_tex_r[4:0]];
      s2_g6_r    <= WIDEN6_LUT[s1_tex_r[10:5]];
      s2_g5_r    <= WIDEN5_LUT[s1_tex_r[9:5]];
      s2_r565_r  <= WIDEN5_LUT[s1_tex_r[15:11]];
      s2_r555_r  <= WIDEN5_LUT[s1_tex_r[14:10]];
    end
  end

  // stage 3: per-format byte selection into the output register
  out_word_t out_nxt;
  out_word_t out_r;

  always_comb begin
    out_nxt               = '0;
    out_nxt.alpha_present = s2_alpha_r;
    case (s2_fmt_r)
      FMT_PAL8: begin
        out_nxt.out_byte0 = s2_pal_r[23:16];
        out_nxt.out_byte1 = s2_pal_r[15:8];
        out_nxt.out_byte2 = s2_pal_r[7:0];
        out_nxt.out_byte3 = s2_pal_r[31:24];
      end
      FMT_8888: begin
        out_nxt.out_byte0 = s2_tex_r[7:0];
        out_nxt.out_byte1 = s2_tex_r[15:8];
        out_nxt.out_byte2 = s2_tex_r[23:16];
        out_nxt.out_byte3 = s2_tex_r[31:24];
      end
      FMT_888: begin
        out_nxt.out_byte0 = s2_tex_r[7:0];
        out_nxt.out_byte1 = s2_tex_r[15:8];
        out_nxt.out_byte2 = s2_tex_r[23:16];
        out_nxt.out_byte3 = BYTE_OPAQUE;
      end
      FMT_LUM8: begin
        out_nxt.out_byte0 = s2_tex_r[7:0];
        out_nxt.out_byte1 = s2_tex_r[7:0];
        out_nxt.out_byte2 = s2_tex_r[7:0];
        out_nxt.out_byte3 = BYTE_OPAQUE;
      end
      FMT_565: begin
        out_nxt.out_byte0 = s2_b5_r;
        out_nxt.out_byte1 = s2_g6_r;
        out_nxt.out_byte2 = s2_r565_r;
        out_nxt.out_byte3 = BYTE_OPAQUE;
      end
      FMT_4444: begin
        // nibble times 17 is the nibble repeated
        out_nxt.out_byte0 = {s2_tex_r[3:0], s2_tex_r[3:0]};
        out_nxt.out_byte1 = {s2_tex_r[7:4], s2_tex_r[7:4]};
        out_nxt.out_byte2 = {s2_tex_r[11:8], s2_tex_r[11:8]};
        out_nxt.out_byte3 = {s2_tex_r[15:12], s2_tex_r[15:12]};
      end
      FMT_1555: begin
        out_nxt.out_byte0 = s2_b5_r;
        out_nxt.out_byte1 = s2_g5_r;
        out_nxt.out_byte2 = s2_r555_r;
        out_nxt.out_byte3 = s2_tex_r[15] ? BYTE_OPAQUE : 8'h00;
      end
      FMT_555: begin
        out_nxt.out_byte0 = s2_b5_r;
        out_nxt.out_byte1 = s2_g5_r;
        out_nxt.out_byte2 = s2_r555_r;
        out_nxt.out_byte3 = BYTE_OPAQUE;
      end
      default: begin
        out_nxt.out_byte3 = BYTE_OPAQUE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s3_take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

  // a palette write never enters the pipeline
  a_pal_write_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.kind == KIND_PAL_WRITE) |=> !v1_r)
    else $error("palette write produced a pipeline word");

  // a word in stage 1 moving on lands in stage 2
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && s2_take) |=> v2_r)
    else $error("word lost between stage 1 and stage 2");

  // input is held off only when every stage is full and the output stalls
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  // a stalled output word stays valid
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_ready) |=> (v3_r && $stable(out_r)))
    else $error("output word dropped or changed under stall");

endmodule

@@ test/tb_texel_format_to_bgra8888.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_texel_format_to_bgra8888
// Self-checking bench for the texel format to BGRA8888 converter. A short
// table of directed words covers every source format, its extreme texels
// and palette writes and lookups. Randomized phases follow, one per
// register setting. Accepted conversion words with no typed expectation
// run through a behavioral converter with its own registers and palette.
// Each result word is compared against the oldest expected one, by field.
// ----------------------------------------------------------------------------
module tb_texel_format_to_bgra8888;
  import tfbgra_pkg::*;

  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 120;
  localparam int QUIET_PHASES    = 2;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    fmt_t      fmt;
    logic      alpha_flag;
    in_word_t  word;
    logic      pinned;
    out_word_t bgra;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_word_t               in_data;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_word_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // converter state as the bench sees it
  fmt_t        cur_fmt        = FMT_8888;
  logic        cur_alpha_flag = 1'b0;
  logic [31:0] palette_mirror [256];
  bit          palette_filled [256];
  out_word_t   bgra_expected [$];

  // typed expectation riding along with the word on the input channel
  logic      pinned_next = 1'b0;
  out_word_t pinned_bgra = '0;

  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  int err_count   = 0;

  texel_format_to_bgra8888 u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // channel widening, truncated
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return 8'((int'(v) * 255) / 31);
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return 8'((int'(v) * 255) / 63);
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return 8'(int'(v) * 17);
  endfunction

  // expected BGRA word for one texel under the current settings
  function automatic out_word_t texel_to_bgra(input in_word_t w);
    logic [15:0] px;
    logic [31:0] entry;
    out_word_t   r;
    px = w.texel_bytes[15:0];
    r  = '0;
    case (cur_fmt)
      FMT_PAL8: begin
        // entry holds R,G,B,A from the low byte up
        entry       = palette_mirror[w.texel_bytes[7:0]];
        r.out_byte0 = entry[23:16];
        r.out_byte1 = entry[15:8];
        r.out_byte2 = entry[7:0];
        r.out_byte3 = entry[31:24];
      end
      FMT_8888: begin
        {r.out_byte3, r.out_byte2, r.out_byte1, r.out_byte0} = w.texel_bytes;
      end
      FMT_888: begin
        {r.out_byte2, r.out_byte1, r.out_byte0} = w.texel_bytes[23:0];
        r.out_byte3 = BYTE_OPAQUE;
      end
      FMT_LUM8: begin
        r.out_byte0 = w.texel_bytes[7:0];
        r.out_byte1 = w.texel_bytes[7:0];
        r.out_byte2 = w.texel_bytes[7:0];
        r.out_byte3 = BYTE_OPAQUE;
      end
      FMT_565: begin
        r.out_byte0 = widen5(px[4:0]);
        r.out_byte1 = widen6(px[10:5]);
        r.out_byte2 = widen5(px[15:11]);
        r.out_byte3 = BYTE_OPAQUE;
      end
      FMT_4444: begin
        r.out_byte0 = widen4(px[3:0]);
        r.out_byte1 = widen4(px[7:4]);
        r.out_byte2 = widen4(px[11:8]);
        r.out_byte3 = widen4(px[15:12]);
      end
      default: begin
        // 1555 and 555 share the color layout
        r.out_byte0 = widen5(px[4:0]);
        r.out_byte1 = widen5(px[9:5]);
        r.out_byte2 = widen5(px[14:10]);
        r.out_byte3 = (cur_fmt == FMT_1555 && !px[15]) ? 8'h00 : BYTE_OPAQUE;
      end
    endcase
    r.alpha_present = cur_alpha_flag || (cur_fmt inside {FMT_8888, FMT_4444, FMT_1555});
    return r;
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (bgra_expected.size() == 0) begin
      report_error($sformatf("result word %h with none expected", got));
    end else begin
      want = bgra_expected.pop_front();
      if (got.out_byte0 !== want.out_byte0)
        report_error($sformatf("byte0 got %h want %h", got.out_byte0, want.out_byte0));
      if (got.out_byte1 !== want.out_byte1)
        report_error($sformatf("byte1 got %h want %h", got.out_byte1, want.out_byte1));
      if (got.out_byte2 !== want.out_byte2)
        report_error($sformatf("byte2 got %h want %h", got.out_byte2, want.out_byte2));
      if (got.out_byte3 !== want.out_byte3)
        report_error($sformatf("byte3 got %h want %h", got.out_byte3, want.out_byte3));
      if (got.alpha_present !== want.alpha_present)
        report_error($sformatf("alpha_present got %b want %b",
                               got.alpha_present, want.alpha_present));
    end
  endtask

  // track register writes, palette writes and results at each handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SOURCE_FORMAT:     cur_fmt = fmt_t'(cfg_data);
          CFG_SOURCE_ALPHA_FLAG: cur_alpha_flag = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_PAL_WRITE) begin
          palette_mirror[in_data.entry_index] = in_data.entry_color;
          palette_filled[in_data.entry_index] = 1'b1;
        end else begin
          bgra_expected.push_back(pinned_next ? pinned_bgra : texel_to_bgra(in_data));
        end
      end
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // receiver stalls in random bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ends the run when no channel moves a word for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input in_word_t w, input logic pinned, input out_word_t bgra);
    int gap;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pinned_next = pinned;
    pinned_bgra = bgra;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold off input until every expected word is out and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (bgra_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // leaves cfg_valid high, the caller lowers it after the last write
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] dat);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dat;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input fmt_t f, input logic a);
    wait_idle();
    cfg_write(CFG_SOURCE_FORMAT, f);
    // upper data bits are don't care for the flag
    cfg_write(CFG_SOURCE_ALPHA_FLAG, {2'($urandom_range(0, 3)), a});
    cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
              3'($urandom_range(0, 7)));
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_row_t conv_row(input fmt_t f, input logic a,
                                        input logic [31:0] tex);
    dir_row_t r;
    r                  = '0;
    r.fmt              = f;
    r.alpha_flag       = a;
    r.word.kind        = KIND_CONVERT;
    r.word.texel_bytes = tex;
    return r;
  endfunction

  function automatic dir_row_t known_row(input fmt_t f, input logic a,
                                         input logic [31:0] tex,
                                         input logic [7:0] b0, b1, b2, b3,
                                         input logic ap);
    dir_row_t r;
    r        = conv_row(f, a, tex);
    r.pinned = 1'b1;
    r.bgra   = {b0, b1, b2, b3, ap};
    return r;
  endfunction

  function automatic dir_row_t pal_row(input fmt_t f, input logic a,
                                       input logic [7:0] idx, input logic [31:0] color);
    dir_row_t r;
    r                  = conv_row(f, a, 32'hFFFF_FFFF);
    r.word.kind        = KIND_PAL_WRITE;
    r.word.entry_index = idx;
    r.word.entry_color = color;
    return r;
  endfunction

  initial begin
    dir_row_t    rows [$];
    in_word_t    w;
    fmt_t        f;
    logic        a;
    logic [7:0]  idx;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // directed words; the first rows run on the reset settings
    rows.push_back(known_row(FMT_8888, 0, 32'h4433_2211, 8'h11, 8'h22, 8'h33, 8'h44, 1));
    rows.push_back(known_row(FMT_8888, 0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1));
    rows.push_back(known_row(FMT_8888, 0, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 1));
    rows.push_back(pal_row(FMT_8888, 0, 8'h00, 32'h4433_2211));
    rows.push_back(pal_row(FMT_8888, 0, 8'hFF, 32'hDDCC_BBAA));
    rows.push_back(pal_row(FMT_8888, 0, 8'h55, 32'h0F1E_2D3C));
    // palette lookup swaps red and blue, high texel bytes ignored
    rows.push_back(known_row(FMT_PAL8, 0, 32'hFFFF_FF00, 8'h33, 8'h22, 8'h11, 8'h44, 0));
    rows.push_back(known_row(FMT_PAL8, 0, 32'h0000_00FF, 8'hCC, 8'hBB, 8'hAA, 8'hDD, 0));
    rows.push_back(conv_row(FMT_PAL8, 0, 32'h5A5A_5A55));
    rows.push_back(known_row(FMT_888, 0, 32'hA512_3456, 8'h56, 8'h34, 8'h12, 8'hFF, 0));
    rows.push_back(known_row(FMT_888, 0, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
    rows.push_back(known_row(FMT_LUM8, 1, 32'hFFFF_FFC3, 8'hC3, 8'hC3, 8'hC3, 8'hFF, 1));
    rows.push_back(known_row(FMT_565, 0, 32'hABCD_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
    rows.push_back(known_row(FMT_565, 0, 32'hFFFF_0000, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
    rows.push_back(conv_row(FMT_565, 0, 32'h0000_1234));
    rows.push_back(known_row(FMT_4444, 0, 32'h0000_F0F0, 8'h00, 8'hFF, 8'h00, 8'hFF, 1));
    rows.push_back(conv_row(FMT_4444, 0, 32'h1234_8421));
    rows.push_back(known_row(FMT_1555, 0, 32'h0000_8000, 8'h00, 8'h00, 8'h00, 8'hFF, 1));
    rows.push_back(known_row(FMT_1555, 0, 32'h0000_7FFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1));
    rows.push_back(known_row(FMT_555, 0, 32'h0000_7FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
    rows.push_back(known_row(FMT_555, 0, 32'hFFFF_8000, 8'h00, 8'h00, 8'h00, 8'hFF, 0));
    rows.push_back(conv_row(FMT_555, 1, 32'h0000_5A5A));
    // overwrite an entry, then read it back right away
    rows.push_back(pal_row(FMT_PAL8, 1, 8'h00, 32'h8899_AABB));
    rows.push_back(conv_row(FMT_PAL8, 1, 32'h0000_0000));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].fmt != cur_fmt || rows[k].alpha_flag != cur_alpha_flag)
        set_config(rows[k].fmt, rows[k].alpha_flag);
      send_word(rows[k].word, rows[k].pinned, rows[k].bgra);
    end

    // random phases, one register setting each, the last ones without idling
    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES - QUIET_PHASES) begin
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
      end else begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      f = (p < 8) ? fmt_t'(p) : fmt_t'($urandom_range(0, 7));
      a = (p < 8) ? p[1] : 1'($urandom_range(0, 1));
      set_config(f, a);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        w.kind = ($urandom_range(0, 4) == 0) ? KIND_PAL_WRITE : KIND_CONVERT;
        case ($urandom_range(0, 7))
          0:       w.texel_bytes = '0;
          1:       w.texel_bytes = '1;
          default: w.texel_bytes = $urandom();
        endcase
        w.entry_index = 8'($urandom_range(0, 255));
        w.entry_color = $urandom();
        // lookups only hit entries that were written
        if (w.kind == KIND_CONVERT && f == FMT_PAL8) begin
          do idx = 8'($urandom_range(0, 255)); while (!palette_filled[idx]);
          w.texel_bytes[7:0] = idx;
        end
        send_word(w, 1'b0, '0);
      end
    end

    wait_idle();
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
